[rtl/bswi_pkg.sv]
// ----------------------------------------------------------------------------
// bswi_pkg: shared types and codes for the bounded stack with insert
// Request and status codes, controller states, and the command and status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bswi_pkg;

    localparam int OP_W   = 2;
    localparam int VAL_W  = 64;
    localparam int POS_W  = 4;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE
    } state_t;

    typedef struct packed {
        logic              push;
        logic              pop_rd;
        logic              pop_out;
        logic              ins_load;
        logic              shift_rd;
        logic              shift_wr;
        logic              place;
        logic              reject;
        logic [STAT_W-1:0] rej_code;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic bad_pos;
        logic at_top;
        logic shift_last;
    } dp_stat_t;

endpackage

`default_nettype wire

[rtl/bswi_ram.sv]
// ----------------------------------------------------------------------------
// bswi_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bswi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/bswi_datapath.sv]
// ----------------------------------------------------------------------------
// bswi_datapath: word store, count, capacity and result register
// Executes controller commands and reports full, empty and position checks.
// ----------------------------------------------------------------------------
`default_nettype none

module bswi_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [bswi_pkg::CAP_W-1:0]       cfg_data,
    input  wire logic [bswi_pkg::VAL_W-1:0]       value,
    input  wire logic [bswi_pkg::POS_W-1:0]       position,
    input  wire bswi_pkg::cmd_t                   cmd,
    output bswi_pkg::dp_stat_t                    stat,
    output logic      [bswi_pkg::STAT_W-1:0]      status,
    output logic      [bswi_pkg::VAL_W-1:0]       popped,
    output logic      [bswi_pkg::CNT_W-1:0]       count
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CMW = (CW > bswi_pkg::CAP_W) ? CW : bswi_pkg::CAP_W;
    localparam int VW  = bswi_pkg::VAL_W;

    logic [CW-1:0]                    fill_reg, fill_next;
    logic [bswi_pkg::CAP_W-1:0]       cap_reg;
    logic [AW-1:0]                    k_reg;
    logic [AW-1:0]                    pos_reg;
    logic [DATA_WIDTH-1:0]            word_reg;
    logic [bswi_pkg::STAT_W-1:0]      status_reg;
    logic [VW-1:0]                    popped_reg;
    logic [bswi_pkg::CNT_W-1:0]       count_reg;

    logic [CMW-1:0]                   fill_ext, cap_ext, usable, pos_ext, cnt_ext;
    logic [CW-1:0]                    fill_dec, fill_inc;
    logic [AW-1:0]                    k_dec;
    logic                             ram_we, ram_re;
    logic [AW-1:0]                    ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0]            ram_wdata, ram_rdata;

    assign fill_ext = CMW'(fill_reg);
    assign cap_ext  = CMW'(cap_reg);
    assign usable   = (cap_ext > CMW'(DEPTH)) ? CMW'(DEPTH) : cap_ext;
    assign pos_ext  = CMW'(position);
    assign fill_dec = fill_reg - CW'(1);
    assign fill_inc = fill_reg + CW'(1);
    assign k_dec    = k_reg - AW'(1);

    assign stat.full       = (fill_ext >= usable);
    assign stat.empty      = (fill_reg == '0);
    assign stat.bad_pos    = (pos_ext > fill_ext);
    assign stat.at_top     = (pos_ext == fill_ext);
    assign stat.shift_last = (k_dec == pos_reg);

    always_comb
    begin
        ram_we    = cmd.push | cmd.shift_wr | cmd.place;
        ram_re    = cmd.pop_rd | cmd.shift_rd;
        ram_waddr = pos_reg;
        ram_wdata = word_reg;
        if (cmd.push)
        begin
            ram_waddr = fill_reg[AW-1:0];
            ram_wdata = value[DATA_WIDTH-1:0];
        end
        else if (cmd.shift_wr)
        begin
            ram_waddr = k_reg;
            ram_wdata = ram_rdata;
        end
        ram_raddr = cmd.pop_rd ? fill_dec[AW-1:0] : k_dec;
    end

    bswi_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.push || cmd.place)
        begin
            fill_next = fill_inc;
        end
        else if (cmd.pop_rd)
        begin
            fill_next = fill_dec;
        end
    end

    assign cnt_ext = CMW'(fill_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            cap_reg  <= bswi_pkg::CAP_RESET;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_load)
        begin
            k_reg    <= fill_reg[AW-1:0];
            pos_reg  <= AW'(position);
            word_reg <= value[DATA_WIDTH-1:0];
        end
        else if (cmd.shift_wr)
        begin
            k_reg <= k_dec;
        end

        if (cmd.push || cmd.place || cmd.pop_out || cmd.reject)
        begin
            status_reg <= cmd.reject ? cmd.rej_code : bswi_pkg::STAT_OK;
            popped_reg <= cmd.pop_out ? VW'(ram_rdata) : '0;
            count_reg  <= cnt_ext[bswi_pkg::CNT_W-1:0];
        end
    end

    assign status = status_reg;
    assign popped = popped_reg;
    assign count  = count_reg;

endmodule

`default_nettype wire

[rtl/bswi_ctrl.sv]
// ----------------------------------------------------------------------------
// bswi_ctrl: request sequencer for the bounded stack with insert
// Decodes requests, steps the insert shift, owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module bswi_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [bswi_pkg::OP_W-1:0]    operation,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    input  wire bswi_pkg::dp_stat_t           stat,
    output bswi_pkg::cmd_t                    cmd
);

    bswi_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             accept;
    logic             load;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == bswi_pkg::S_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            bswi_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        bswi_pkg::OP_PUSH:
                        begin
                            if (stat.full)
                            begin
                                cmd.reject   = 1'b1;
                                cmd.rej_code = bswi_pkg::STAT_FULL;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                            end
                        end
                        bswi_pkg::OP_POP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.reject   = 1'b1;
                                cmd.rej_code = bswi_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.pop_rd = 1'b1;
                                state_next = bswi_pkg::S_POP;
                            end
                        end
                        bswi_pkg::OP_INSERT:
                        begin
                            if (stat.bad_pos)
                            begin
                                cmd.reject   = 1'b1;
                                cmd.rej_code = bswi_pkg::STAT_BADPOS;
                            end
                            else if (stat.full)
                            begin
                                cmd.reject   = 1'b1;
                                cmd.rej_code = bswi_pkg::STAT_FULL;
                            end
                            else if (stat.at_top)
                            begin
                                cmd.push = 1'b1;
                            end
                            else
                            begin
                                cmd.ins_load = 1'b1;
                                state_next   = bswi_pkg::S_SHIFT_RD;
                            end
                        end
                        default:
                        begin
                            cmd.reject   = 1'b1;
                            cmd.rej_code = bswi_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            bswi_pkg::S_POP:
            begin
                cmd.pop_out = 1'b1;
                state_next  = bswi_pkg::S_IDLE;
            end
            bswi_pkg::S_SHIFT_RD:
            begin
                cmd.shift_rd = 1'b1;
                state_next   = bswi_pkg::S_SHIFT_WR;
            end
            bswi_pkg::S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = stat.shift_last ? bswi_pkg::S_PLACE : bswi_pkg::S_SHIFT_RD;
            end
            bswi_pkg::S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = bswi_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bswi_pkg::S_IDLE;
            end
        endcase
    end

    assign load           = cmd.push | cmd.place | cmd.pop_out | cmd.reject;
    assign out_valid_next = load | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bswi_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/bounded_stack_with_insert.sv]
// ----------------------------------------------------------------------------
// bounded_stack_with_insert: LIFO word stack with positional insert
// Push, pop or insert at a position; one status/popped/count item per request.
// ----------------------------------------------------------------------------
// Steps: push, a refused request or an unused code writes the result
// register directly; pop reads the RAM (registered read), then returns
// the word; an insert below the top loads the request, moves each entry
// above the position up by one RAM read and one RAM write, then places
// the word. A new request is taken once the previous one is finished and
// the result register is free or draining. The capacity register is
// written through the cfg channel (always ready) and caps at DEPTH. The
// word store is a RAM with no reset; only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_with_insert #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bswi_pkg::CAP_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [bswi_pkg::OP_W-1:0]      operation,
    input  wire logic [bswi_pkg::VAL_W-1:0]     value,
    input  wire logic [bswi_pkg::POS_W-1:0]     position,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [bswi_pkg::STAT_W-1:0]    status,
    output logic      [bswi_pkg::VAL_W-1:0]     popped,
    output logic      [bswi_pkg::CNT_W-1:0]     count
);

    bswi_pkg::cmd_t     cmd;
    bswi_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    bswi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bswi_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .value    (value),
        .position (position),
        .cmd      (cmd),
        .stat     (stat),
        .status   (status),
        .popped   (popped),
        .count    (count)
    );

endmodule

`default_nettype wire
